// ----- rtl/core/rtph_pkg.sv -----
// ============================================================================
// rtph_pkg
// Shared types and constants for the rectangular-to-polar heading pipeline.
// ============================================================================
package rtph_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // Result field widths
    localparam int DIST_BITS = 16;
    localparam int HEAD_BITS = 17;

    // CORDIC datapath: coordinates are left-aligned to bit 60 in a 64-bit word
    localparam int CORDIC_STEPS   = 26;
    localparam int CORDIC_W       = 64;
    localparam int ALIGN_BIT      = 60;
    // Angle accumulator in degrees with 24 fraction bits
    localparam int ANG_UNIT_BITS  = 24;
    localparam int ANG_W          = 32;
    // Clamped first-quadrant angle, 0..90 degrees
    localparam int ANG_CLAMP_W    = 31;
    // Heading before rounding, 0..360 degrees plus half a step
    localparam int HEAD_WIDE_W    = 34;

    // Heading stage count after the CORDIC iterations: clamp, offset, round/wrap
    localparam int HEAD_POST_STAGES = 3;
    localparam int CORDIC_LAT       = CORDIC_STEPS + HEAD_POST_STAGES;

    // Square root stage count outside the per-bit iterations: square, sum, round
    localparam int SQRT_EXTRA_STAGES = 3;

    localparam logic signed [ANG_W-1:0] DEG90_Z = ANG_W'(90) <<< ANG_UNIT_BITS;

    // atan(2^-i) in degrees times 2^24
    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489089, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29
    };

    // Sign and zero flags of the input point
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
    } quad_t;

endpackage

// ----- rtl/core/rtph_pos_if.sv -----
// ============================================================================
// rtph_pos_if
// Request channel carrying one signed position sample.
// ============================================================================
interface rtph_pos_if #(
    parameter int COORD_WIDTH = 16
) ();

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;

    modport source (
        output valid,
        output pos_x,
        output pos_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  pos_x,
        input  pos_y,
        output ready
    );

endinterface

// ----- rtl/core/rtph_polar_if.sv -----
// ============================================================================
// rtph_polar_if
// Result channel carrying one distance and heading result.
// ============================================================================
interface rtph_polar_if
    import rtph_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] distance;
    logic [HEAD_BITS-1:0] heading;

    modport source (
        output valid,
        output distance,
        output heading,
        input  ready
    );

    modport sink (
        input  valid,
        input  distance,
        input  heading,
        output ready
    );

endinterface

// ----- rtl/core/rect_to_polar_heading.sv -----
// ============================================================================
// rect_to_polar_heading
// Distance and heading of a signed position relative to the origin.
// ============================================================================
// Each request (pos_x, pos_y) yields one result: the distance to the origin
// rounded to the nearest unit (halves round up) and a heading in degrees with
// ANGLE_FRAC_BITS fraction bits, equal to atan2(y,x) + 90 wrapped into 0..360
// (+X is 90, +Y is 180, -X is 270, -Y is 0, the origin gives 0 and 0). A new
// request is taken every cycle while no result waits on the output. The
// path runs through one input stage, then the longer of the 26-stage CORDIC
// plus three heading stages and the square root at one result bit per stage
// plus square, sum and rounding stages. The whole pipeline holds while a
// result waits on the output, so ready drops only when the final stage is
// full and not taken.
// ============================================================================
module rect_to_polar_heading
    import rtph_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rtph_pos_if.sink      pos,
    rtph_polar_if.source  polar
);

    localparam int SQRT_LAT = COORD_WIDTH + SQRT_EXTRA_STAGES;
    localparam int PIPE_LAT = (SQRT_LAT > CORDIC_LAT) ? SQRT_LAT : CORDIC_LAT;

    logic                   en;
    logic [PIPE_LAT:0]      vld_reg;
    logic [PIPE_LAT:0]      vld_next;

    logic [COORD_WIDTH-1:0] ax_reg;
    logic [COORD_WIDTH-1:0] ay_reg;
    quad_t                  quad_reg;
    quad_t                  quad_next;

    // Global advance: move when the output stage is empty or being taken
    assign en        = !vld_reg[PIPE_LAT] || polar.ready;
    assign pos.ready = en;
    assign vld_next  = {vld_reg[PIPE_LAT-1:0], pos.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Input stage: magnitudes and sign/zero flags
    assign quad_next.x_neg  = pos.pos_x[COORD_WIDTH-1];
    assign quad_next.y_neg  = pos.pos_y[COORD_WIDTH-1];
    assign quad_next.x_zero = (pos.pos_x == '0);
    assign quad_next.y_zero = (pos.pos_y == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= quad_next.x_neg ? (~pos.pos_x + 1'b1) : pos.pos_x;
            ay_reg   <= quad_next.y_neg ? (~pos.pos_y + 1'b1) : pos.pos_y;
            quad_reg <= quad_next;
        end
    end

    rtph_sqrt #(
        .COORD_WIDTH (COORD_WIDTH),
        .LAT         (PIPE_LAT)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .ax       (ax_reg),
        .ay       (ay_reg),
        .distance (polar.distance)
    );

    rtph_cordic #(
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .LAT             (PIPE_LAT)
    ) u_cordic (
        .clk     (clk),
        .en      (en),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .quad    (quad_reg),
        .heading (polar.heading)
    );

    assign polar.valid = vld_reg[PIPE_LAT];

endmodule

// ----- rtl/core/rtph_cordic.sv -----
// ============================================================================
// rtph_cordic
// Unrolled CORDIC vectoring pipeline: one iteration per stage, then clamp,
// quadrant offset and rounding/wrap of the heading.
// ============================================================================
module rtph_cordic
    import rtph_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int LAT             = CORDIC_LAT
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [COORD_WIDTH-1:0] ax,
    input  logic [COORD_WIDTH-1:0] ay,
    input  quad_t                  quad,
    output logic [HEAD_BITS-1:0]   heading
);

    localparam int PRE_SHIFT = ALIGN_BIT - COORD_WIDTH;
    localparam int RND_SHIFT = ANG_UNIT_BITS - ANGLE_FRAC_BITS;
    localparam int PAD       = LAT - CORDIC_LAT;

    localparam logic [HEAD_WIDE_W-1:0] HALF   = HEAD_WIDE_W'(1) << (RND_SHIFT - 1);
    localparam logic [HEAD_WIDE_W-1:0] OFS90  = (HEAD_WIDE_W'(90) << ANG_UNIT_BITS) + HALF;
    localparam logic [HEAD_WIDE_W-1:0] OFS270 = (HEAD_WIDE_W'(270) << ANG_UNIT_BITS) + HALF;
    localparam logic [HEAD_WIDE_W-1:0] FULL   = HEAD_WIDE_W'(360) << ANGLE_FRAC_BITS;
    localparam logic [HEAD_WIDE_W-1:0] DEG90  = HEAD_WIDE_W'(90) << ANGLE_FRAC_BITS;
    localparam logic [HEAD_WIDE_W-1:0] DEG180 = HEAD_WIDE_W'(180) << ANGLE_FRAC_BITS;
    localparam logic [HEAD_WIDE_W-1:0] DEG270 = HEAD_WIDE_W'(270) << ANGLE_FRAC_BITS;

    logic signed [CORDIC_W-1:0] cx_init;
    logic signed [CORDIC_W-1:0] cy_init;

    logic signed [CORDIC_W-1:0] cx_reg   [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cy_reg   [CORDIC_STEPS];
    logic signed [ANG_W-1:0]    z_reg    [CORDIC_STEPS];
    quad_t                      quad_reg [CORDIC_STEPS];

    logic [ANG_CLAMP_W-1:0] a_reg;
    logic [ANG_CLAMP_W-1:0] a_next;
    quad_t                  quad_a_reg;

    logic [HEAD_WIDE_W-1:0] h_reg;
    logic [HEAD_WIDE_W-1:0] h_next;
    logic [HEAD_WIDE_W-1:0] h_base;
    quad_t                  quad_h_reg;

    logic [HEAD_WIDE_W-1:0] h_shift;
    logic [HEAD_WIDE_W-1:0] h_wrap;
    logic [HEAD_BITS-1:0]   head_reg;
    logic [HEAD_BITS-1:0]   head_next;

    // Left-align the magnitudes in the wide datapath
    assign cx_init = signed'(CORDIC_W'(ax) << PRE_SHIFT);
    assign cy_init = signed'(CORDIC_W'(ay) << PRE_SHIFT);

    // One vectoring iteration per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [CORDIC_W-1:0] cx_src;
        logic signed [CORDIC_W-1:0] cy_src;
        logic signed [ANG_W-1:0]    z_src;
        quad_t                      quad_src;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;

        if (i == 0) begin : g_first
            assign cx_src   = cx_init;
            assign cy_src   = cy_init;
            assign z_src    = '0;
            assign quad_src = quad;
        end else begin : g_next
            assign cx_src   = cx_reg[i-1];
            assign cy_src   = cy_reg[i-1];
            assign z_src    = z_reg[i-1];
            assign quad_src = quad_reg[i-1];
        end

        // Arithmetic shift floors negative values
        assign dx = cy_src >>> i;
        assign dy = cx_src >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cy_src[CORDIC_W-1])
                begin
                    cx_reg[i] <= cx_src + dx;
                    cy_reg[i] <= cy_src - dy;
                    z_reg[i]  <= z_src + ATAN_TAB[i];
                end
                else
                begin
                    cx_reg[i] <= cx_src - dx;
                    cy_reg[i] <= cy_src + dy;
                    z_reg[i]  <= z_src - ATAN_TAB[i];
                end
                quad_reg[i] <= quad_src;
            end
        end
    end

    // Clamp the angle to 0..90 degrees
    always_comb
    begin
        priority if (z_reg[CORDIC_STEPS-1][ANG_W-1])
            a_next = '0;
        else if (z_reg[CORDIC_STEPS-1] > DEG90_Z)
            a_next = ANG_CLAMP_W'(DEG90_Z);
        else
            a_next = ANG_CLAMP_W'(z_reg[CORDIC_STEPS-1]);
    end

    // Quadrant offset with the rounding half folded in
    always_comb
    begin
        h_base = quad_a_reg.x_neg ? OFS270 : OFS90;
        if (quad_a_reg.x_neg ^ quad_a_reg.y_neg)
            h_next = h_base - HEAD_WIDE_W'(a_reg);
        else
            h_next = h_base + HEAD_WIDE_W'(a_reg);
    end

    // Round to the output step, wrap 360 to 0, exact values on the axes
    always_comb
    begin
        h_shift = h_reg >> RND_SHIFT;
        h_wrap  = (h_shift >= FULL) ? (h_shift - FULL) : h_shift;
        priority if (quad_h_reg.x_zero && quad_h_reg.y_zero)
            head_next = '0;
        else if (quad_h_reg.x_zero)
            head_next = quad_h_reg.y_neg ? '0 : DEG180[HEAD_BITS-1:0];
        else if (quad_h_reg.y_zero)
            head_next = quad_h_reg.x_neg ? DEG270[HEAD_BITS-1:0] : DEG90[HEAD_BITS-1:0];
        else
            head_next = h_wrap[HEAD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= a_next;
            quad_a_reg <= quad_reg[CORDIC_STEPS-1];
            h_reg      <= h_next;
            quad_h_reg <= quad_a_reg;
            head_reg   <= head_next;
        end
    end

    // Delay to line up with the distance path
    if (PAD > 0) begin : g_pad
        logic [HEAD_BITS-1:0] dly_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
                dly_reg[0] <= head_reg;
        end

        for (genvar p = 1; p < PAD; p++) begin : g_tap
            always_ff @(posedge clk)
            begin
                if (en)
                    dly_reg[p] <= dly_reg[p-1];
            end
        end

        assign heading = dly_reg[PAD-1];
    end else begin : g_nopad
        assign heading = head_reg;
    end

endmodule

// ----- rtl/core/rtph_sqrt.sv -----
// ============================================================================
// rtph_sqrt
// Distance pipeline: squares, sum, one square-root bit per stage, then
// round to nearest using the final remainder.
// ============================================================================
module rtph_sqrt
    import rtph_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int LAT         = COORD_WIDTH_DEF + SQRT_EXTRA_STAGES
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [COORD_WIDTH-1:0] ax,
    input  logic [COORD_WIDTH-1:0] ay,
    output logic [DIST_BITS-1:0]   distance
);

    localparam int SQ_W    = 2 * COORD_WIDTH;
    localparam int OWN_LAT = COORD_WIDTH + SQRT_EXTRA_STAGES;
    localparam int PAD     = LAT - OWN_LAT;
    localparam int DWIDE   = (COORD_WIDTH + 1 > DIST_BITS) ? COORD_WIDTH + 1 : DIST_BITS;

    logic [SQ_W-1:0]        sqx_reg;
    logic [SQ_W-1:0]        sqy_reg;
    logic [SQ_W-1:0]        n_reg;

    logic [SQ_W-1:0]        rem_reg  [COORD_WIDTH];
    logic [COORD_WIDTH-1:0] root_reg [COORD_WIDTH];

    logic [DWIDE-1:0]       dist_wide;
    logic [DIST_BITS-1:0]   dist_reg;

    // Squares, then their sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= SQ_W'(ax) * SQ_W'(ax);
            sqy_reg <= SQ_W'(ay) * SQ_W'(ay);
            n_reg   <= sqx_reg + sqy_reg;
        end
    end

    // Restoring square root, most significant result bit first
    for (genvar j = 0; j < COORD_WIDTH; j++) begin : g_bit
        localparam int K = COORD_WIDTH - 1 - j;

        logic [SQ_W-1:0]        rem_src;
        logic [COORD_WIDTH-1:0] root_src;
        logic [SQ_W-1:0]        trial;

        if (j == 0) begin : g_first
            assign rem_src  = n_reg;
            assign root_src = '0;
        end else begin : g_next
            assign rem_src  = rem_reg[j-1];
            assign root_src = root_reg[j-1];
        end

        // (root + 2^K)^2 - root^2
        assign trial = (SQ_W'(root_src) << (K + 1)) + (SQ_W'(1) << (2 * K));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_src >= trial)
                begin
                    rem_reg[j]  <= rem_src - trial;
                    root_reg[j] <= root_src | (COORD_WIDTH'(1) << K);
                end
                else
                begin
                    rem_reg[j]  <= rem_src;
                    root_reg[j] <= root_src;
                end
            end
        end
    end

    // Round up when the remainder exceeds the root
    assign dist_wide = DWIDE'(root_reg[COORD_WIDTH-1])
                     + DWIDE'(rem_reg[COORD_WIDTH-1] > SQ_W'(root_reg[COORD_WIDTH-1]));

    always_ff @(posedge clk)
    begin
        if (en)
            dist_reg <= dist_wide[DIST_BITS-1:0];
    end

    // Delay to line up with the heading path
    if (PAD > 0) begin : g_pad
        logic [DIST_BITS-1:0] dly_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
                dly_reg[0] <= dist_reg;
        end

        for (genvar p = 1; p < PAD; p++) begin : g_tap
            always_ff @(posedge clk)
            begin
                if (en)
                    dly_reg[p] <= dly_reg[p-1];
            end
        end

        assign distance = dly_reg[PAD-1];
    end else begin : g_nopad
        assign distance = dist_reg;
    end

endmodule

// ----- tb/rect_to_polar_heading_checker.sv -----
// ============================================================================
// rect_to_polar_heading_checker
// Watches the position and polar channels, predicts each polar result from
// the accepted position and compares the returned distance and heading with it.
// ============================================================================
module rect_to_polar_heading_checker
    import rtph_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pos_valid,
    input  logic                          pos_ready,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic                          polar_valid,
    input  logic                          polar_ready,
    input  logic [DIST_BITS-1:0]          distance,
    input  logic [HEAD_BITS-1:0]          heading,
    output int                            mismatches,
    output int                            pending,
    output int                            checked
);

    // Vectoring arithmetic: angles in degrees with 24 fraction bits,
    // magnitudes left-aligned to bit 60 of a 64-bit word
    localparam int     ROTATIONS  = 26;
    localparam int     DEG_FRAC   = 24;
    localparam int     PRE_SHIFT  = 60 - COORD_WIDTH;
    localparam int     DROP_BITS  = DEG_FRAC - ANGLE_FRAC_BITS;
    localparam longint RIGHT_ANG  = 64'sd90 <<< DEG_FRAC;
    localparam longint TURN_STEPS = 64'sd360 <<< ANGLE_FRAC_BITS;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_DEG [ROTATIONS] = '{
        754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
        15018523,  7509720,   3754917,   1877466,   938734,   469367,
        234684,    117342,    58671,     29335,     14668,    7334,
        3667,      1833,      917,       458,       229,      115,
        57,        29
    };

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [DIST_BITS-1:0]          distance;
        logic [HEAD_BITS-1:0]          heading;
    } polar_t;

    polar_t pending_polar [$];
    int     fail_count  = 0;
    int     match_count = 0;

    // Bitwise integer square root, rounded down
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        r   = 0;
        rem = n;
        b   = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // atan(ay/ax) for ax, ay > 0, clamped to 0..90 degrees
    function automatic longint first_quadrant_deg(longint unsigned ax, longint unsigned ay);
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        cx = $signed(ax << PRE_SHIFT);
        cy = $signed(ay << PRE_SHIFT);
        z  = 0;
        for (int i = 0; i < ROTATIONS; i++)
        begin
            // arithmetic shift rounds toward minus infinity
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ATAN_DEG[i];
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ATAN_DEG[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > RIGHT_ANG)
            z = RIGHT_ANG;
        return z;
    endfunction

    // Expected distance and heading of one position
    function automatic polar_t predict_polar(logic signed [COORD_WIDTH-1:0] x,
                                             logic signed [COORD_WIDTH-1:0] y);
        polar_t          p;
        longint          sx;
        longint          sy;
        longint          a;
        longint          h;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned n;
        longint unsigned k;
        longint unsigned d;
        longint unsigned hd;
        sx = longint'(x);
        sy = longint'(y);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        n  = ax * ax + ay * ay;
        k  = floor_root(n);
        d  = (n - k * k > k) ? k + 1 : k;

        // Origin and axes are exact; everything else goes through vectoring
        if (sx == 0 && sy == 0)
            hd = 0;
        else if (sx == 0)
            hd = (sy > 0) ? (longint'(180) << ANGLE_FRAC_BITS) : 0;
        else if (sy == 0)
            hd = longint'((sx > 0) ? 90 : 270) << ANGLE_FRAC_BITS;
        else
        begin
            a = first_quadrant_deg(ax, ay);
            if (sx > 0 && sy > 0)
                h = RIGHT_ANG + a;
            else if (sx < 0 && sy > 0)
                h = 3 * RIGHT_ANG - a;
            else if (sx < 0)
                h = 3 * RIGHT_ANG + a;
            else
                h = RIGHT_ANG - a;
            hd = (h + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;
            if (hd >= TURN_STEPS)
                hd = hd - TURN_STEPS;
        end

        p.x        = x;
        p.y        = y;
        p.distance = d[DIST_BITS-1:0];
        p.heading  = hd[HEAD_BITS-1:0];
        return p;
    endfunction

    // Compare results first, then queue the request taken on the same edge
    always @(posedge clk)
    begin : watch
        polar_t want;
        if (rst_n)
        begin
            if (polar_valid && polar_ready)
            begin
                if (pending_polar.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: distance %0d heading %0d",
                                 distance, heading);
                end
                else
                begin
                    want = pending_polar.pop_front();
                    match_count++;
                    if (distance !== want.distance || heading !== want.heading)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch for request (%0d,%0d): distance exp %0d ",
                                      "got %0d, heading exp %0d got %0d"},
                                     want.x, want.y, want.distance, distance,
                                     want.heading, heading);
                    end
                end
            end
            if (pos_valid && pos_ready)
                pending_polar.push_back(predict_polar(pos_x, pos_y));
        end
        mismatches <= fail_count;
        pending    <= pending_polar.size();
        checked    <= match_count;
    end

endmodule

// ----- tb/rect_to_polar_heading_tb.sv -----
// ============================================================================
// rect_to_polar_heading_tb
// Drives position requests into the polar pipeline in random bursts while the
// result side stalls on its own pattern; a checker predicts and compares.
// ============================================================================
module rect_to_polar_heading_tb;
    import rtph_pkg::*;

    localparam int CW              = COORD_WIDTH_DEF;
    localparam int RANDOM_REQUESTS = 1680;
    localparam int DRAIN_EVERY     = 500;
    localparam int SETTLE_CYCLES   = 64;
    localparam int COORD_LO        = -(2 ** (CW - 1));
    localparam int COORD_HI        = (2 ** (CW - 1)) - 1;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   checked;
    int   sent_total;
    int   sent_origin;
    int   sent_axis;

    rtph_pos_if #(.COORD_WIDTH(CW)) pos_ch ();
    rtph_polar_if                   polar_ch ();

    rect_to_polar_heading #(
        .COORD_WIDTH     (CW),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS_DEF)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pos   (pos_ch.sink),
        .polar (polar_ch.source)
    );

    rect_to_polar_heading_checker #(
        .COORD_WIDTH     (CW),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS_DEF)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pos_valid   (pos_ch.valid),
        .pos_ready   (pos_ch.ready),
        .pos_x       (pos_ch.pos_x),
        .pos_y       (pos_ch.pos_y),
        .polar_valid (polar_ch.valid),
        .polar_ready (polar_ch.ready),
        .distance    (polar_ch.distance),
        .heading     (polar_ch.heading),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("rect_to_polar_heading regression: fail");
        $finish;
    end

    // Result-side stalls: modes held for random stretches
    initial
    begin : result_stall
        stall_mode_t mode;
        int          hold;
        int          phase;
        polar_ch.ready = 1'b0;
        mode  = STALL_NONE;
        hold  = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                mode = stall_mode_t'($urandom_range(3, 0));
                hold = $urandom_range(300, 40);
            end
            hold--;
            phase = (phase + 1) % 7;
            case (mode)
                STALL_NONE:  polar_ch.ready <= 1'b1;
                STALL_LIGHT: polar_ch.ready <= ($urandom_range(9, 0) < 7);
                STALL_HEAVY: polar_ch.ready <= ($urandom_range(9, 0) < 2);
                default:     polar_ch.ready <= (phase >= 3);
            endcase
        end
    end

    // One of the extreme coordinate values
    function automatic int extreme_coord();
        case ($urandom_range(6, 0))
            0:       return COORD_LO;
            1:       return COORD_LO + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return COORD_HI - 1;
            default: return COORD_HI;
        endcase
    endfunction

    // Any coordinate in the full signed range
    function automatic int rand_coord();
        return int'($signed(CW'($urandom)));
    endfunction

    // Present one request; valid stays high on return
    task automatic send_position(input int x, input int y);
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= CW'(x);
        pos_ch.pos_y <= CW'(y);
        @(posedge clk);
        while (!pos_ch.ready)
            @(posedge clk);
        sent_total++;
        if (x == 0 && y == 0)
            sent_origin++;
        else if (x == 0 || y == 0)
            sent_axis++;
    endtask

    // Hold until every queued result has come back
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int x;
        int y;
        int sent_random;
        int next_drain;
        int burst;
        int gap;
        int pick;
        int v;
        pos_ch.valid = 1'b0;
        pos_ch.pos_x = '0;
        pos_ch.pos_y = '0;
        rst_n        = 1'b0;
        sent_total   = 0;
        sent_origin  = 0;
        sent_axis    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Origin, unit and full-scale axes
        send_position(0, 0);
        send_position(1, 0);
        send_position(0, 1);
        send_position(-1, 0);
        send_position(0, -1);
        send_position(32767, 0);
        send_position(0, 32767);
        send_position(-32768, 0);
        send_position(0, -32768);
        // Corners, including the most negative value on both coordinates
        send_position(32767, 32767);
        send_position(-32768, 32767);
        send_position(-32768, -32768);
        send_position(32767, -32768);
        // Diagonals in each quadrant, then two off-diagonal integer-distance points
        send_position(1, 1);
        send_position(-1, 1);
        send_position(-1, -1);
        send_position(1, -1);
        send_position(3, 4);
        send_position(-5, -12);
        // Near an axis: angle clamps and the wrap back to zero degrees
        send_position(32767, 1);
        send_position(1, -32768);
        send_position(-1, 32767);
        send_position(-1, -32768);
        pos_ch.valid <= 1'b0;
        wait_drained();

        // Random bursts with varied point shapes
        sent_random = 0;
        next_drain  = DRAIN_EVERY;
        while (sent_random < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(24, 1);
            for (int b = 0; b < burst && sent_random < RANDOM_REQUESTS; b++)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 40)
                begin
                    // anywhere in the plane
                    x = rand_coord();
                    y = rand_coord();
                end
                else if (pick < 55)
                begin
                    // close to the origin
                    v = $urandom_range(16, 0);
                    x = v - 8;
                    v = $urandom_range(16, 0);
                    y = v - 8;
                end
                else if (pick < 67)
                begin
                    // on an axis
                    v = $urandom_range(1, 0);
                    x = v ? extreme_coord() : rand_coord();
                    y = 0;
                    if ($urandom_range(1, 0))
                    begin
                        y = x;
                        x = 0;
                    end
                end
                else if (pick < 77)
                begin
                    // on a diagonal
                    v = $urandom_range(32767, 1);
                    x = $urandom_range(1, 0) ? v : -v;
                    y = $urandom_range(1, 0) ? v : -v;
                end
                else if (pick < 88)
                begin
                    x = extreme_coord();
                    y = extreme_coord();
                end
                else
                begin
                    // just off an axis
                    v = $urandom_range(3, 1);
                    x = $urandom_range(1, 0) ? v : -v;
                    y = $urandom_range(1, 0) ? extreme_coord() : rand_coord();
                    if ($urandom_range(1, 0))
                    begin
                        v = x;
                        x = y;
                        y = v;
                    end
                end
                send_position(x, y);
                sent_random++;
            end

            // Between bursts: a full drain now and then, else a random gap or none
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (sent_random >= next_drain)
            begin
                pos_ch.valid <= 1'b0;
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
            else if (gap > 0)
            begin
                pos_ch.valid <= 1'b0;
                repeat (gap)
                begin
                    pos_ch.pos_x <= CW'($urandom);
                    pos_ch.pos_y <= CW'($urandom);
                    @(posedge clk);
                end
            end
        end

        pos_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d position requests (%0d at the origin, %0d on an axis)",
                 sent_total, sent_origin, sent_axis);
        $display("checked %0d results under bursty requests and result stalls, %0d bad",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("rect_to_polar_heading regression: pass");
        else
            $display("rect_to_polar_heading regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rtph_pkg.sv
rtl/core/rtph_pos_if.sv
rtl/core/rtph_polar_if.sv
rtl/core/rtph_cordic.sv
rtl/core/rtph_sqrt.sv
rtl/core/rect_to_polar_heading.sv
tb/rect_to_polar_heading_checker.sv
tb/rect_to_polar_heading_tb.sv
